>>> rtl/core/lrop_pkg.sv
// Shared types, constants and helper functions for the obstacle route planner.
package lrop_pkg;

	localparam int OBSTACLE_SLOTS_DEF = 16;
	localparam int COORD_BITS_DEF = 24;
	localparam int LEN_BITS = 25;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_PLAN  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_FAIL,
		ST_LEN1,
		ST_OUT1,
		ST_LEN2,
		ST_OUT2
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;        // capture input word
		logic wr_obst;     // write obstacle at count
		logic clr_count;   // empty the table
		logic scan_start;  // reset scan index and flags
		logic scan_step;   // evaluate one table entry
		logic sqrt_start;  // start square root of current leg
		logic sel_leg2;    // 0 first leg, 1 second leg
		logic emit_fail;
		logic emit_seg;    // emit a segment result
		logic emit_last;
	} ctrl_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_done;
		logic sqrt_done;
		logic blocked;
		logic manhattan;
		logic full;
	} stat_t;

endpackage

>>> rtl/core/l_route_obstacle_planner.sv
// Top level of the obstacle-aware route planner.
// A word is taken when start is high and busy is low; kind selects add,
// clear or plan. Add writes the table from ST_ADD, clear acts in ST_IDLE; kind 3 is ignored.
// A plan scans the obstacle table once, one entry a cycle from a RAM with
// registered read, then runs an iterative square root for a COORD_BITS+2
// bit root per leg. The scan and the square root unit, shared by both legs,
// set the time a plan takes.
// Results appear for one cycle with done high; a Manhattan plan gives two
// words in consecutive cycles, the second with last_segment high. A blocked
// start or end gives one failure word. The receiver cannot stall.
// The configuration channel writes the Manhattan mode flag; ready is always high.
// Reset empties the table and sets the Manhattan mode flag to 1.
module l_route_obstacle_planner
	import lrop_pkg::*;
#(
	parameter int OBSTACLE_SLOTS = OBSTACLE_SLOTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   kind,
	input  logic signed [COORD_BITS-1:0] point_a_x,
	input  logic signed [COORD_BITS-1:0] point_a_y,
	input  logic signed [COORD_BITS-1:0] point_b_x,
	input  logic signed [COORD_BITS-1:0] point_b_y,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_data,
	output logic                         done,
	output logic                         found,
	output logic signed [COORD_BITS-1:0] seg_start_x,
	output logic signed [COORD_BITS-1:0] seg_start_y,
	output logic signed [COORD_BITS-1:0] seg_end_x,
	output logic signed [COORD_BITS-1:0] seg_end_y,
	output logic [LEN_BITS-1:0]          seg_length,
	output logic [LEN_BITS-1:0]          total_length,
	output logic                         bend_count,
	output logic                         last_segment
);
	ctrl_t ctl;
	stat_t st;
	logic  manhattan_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			manhattan_q <= 1'b1;
		end else if (cfg_valid) begin
			manhattan_q <= cfg_data;
		end
	end

	lrop_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.busy   (busy),
		.st     (st),
		.ctl    (ctl)
	);

	lrop_dp #(.OBSTACLE_SLOTS(OBSTACLE_SLOTS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.st            (st),
		.cfg_manhattan (manhattan_q),
		.ax_in         (point_a_x),
		.ay_in         (point_a_y),
		.bx_in         (point_b_x),
		.by_in         (point_b_y),
		.done          (done),
		.found         (found),
		.seg_start_x   (seg_start_x),
		.seg_start_y   (seg_start_y),
		.seg_end_x     (seg_end_x),
		.seg_end_y     (seg_end_y),
		.seg_length    (seg_length),
		.total_length  (total_length),
		.bend_count    (bend_count),
		.last_segment  (last_segment)
	);
endmodule

>>> rtl/core/lrop_ram.sv
// Generic RAM with one write port and one registered read port.
module lrop_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/core/lrop_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module lrop_sqrt #(
	parameter int IN_BITS = 52,
	parameter int OUT_BITS = 26
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [IN_BITS-1:0]  radicand,
	output logic                done,
	output logic [OUT_BITS-1:0] root
);
	localparam int CNT_BITS = $clog2(OUT_BITS + 1);

	logic [IN_BITS-1:0]   rem_q;
	logic [OUT_BITS-1:0]  root_q;
	logic [2*OUT_BITS-1:0] src_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q;
	logic [IN_BITS+1:0]   trial;
	logic [IN_BITS+1:0]   rem_sh;

	assign rem_sh = {rem_q, src_q[2*OUT_BITS-1 -: 2]};
	assign trial = rem_sh - {{(IN_BITS + 2 - OUT_BITS - 2){1'b0}}, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_BITS'(OUT_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			root_q <= '0;
			src_q <= (2*OUT_BITS)'(radicand);
		end else if (busy_q) begin
			src_q <= src_q << 2;
			if (!trial[IN_BITS+1]) begin
				rem_q <= trial[IN_BITS-1:0];
				root_q <= {root_q[OUT_BITS-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[IN_BITS-1:0];
				root_q <= {root_q[OUT_BITS-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

>>> rtl/core/lrop_ctrl.sv
// Controller state machine of the obstacle route planner.
module lrop_ctrl
	import lrop_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  [1:0] kind,
	output logic  busy,
	input  stat_t st,
	output ctrl_t ctl
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					unique case (kind)
						KIND_ADD: state_d = ST_ADD;
						KIND_CLEAR: ctl.clr_count = 1'b1;
						KIND_PLAN: begin
							ctl.scan_start = 1'b1;
							state_d = ST_SCAN;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD: begin
				ctl.wr_obst = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				ctl.scan_step = 1'b1;
				if (st.scan_done) begin
					ctl.scan_step = 1'b0;
					if (st.blocked) begin
						state_d = ST_FAIL;
					end else begin
						ctl.sqrt_start = 1'b1;
						state_d = ST_LEN1;
					end
				end
			end
			ST_FAIL: begin
				ctl.emit_fail = 1'b1;
				ctl.emit_last = 1'b1;
				state_d = ST_IDLE;
			end
			ST_LEN1: begin
				if (st.sqrt_done) begin
					if (st.manhattan) begin
						ctl.sqrt_start = 1'b1;
						ctl.sel_leg2 = 1'b1;
						state_d = ST_LEN2;
					end else begin
						state_d = ST_OUT1;
					end
				end
			end
			ST_LEN2: begin
				ctl.sel_leg2 = 1'b1;
				if (st.sqrt_done) begin
					state_d = ST_OUT1;
				end
			end
			ST_OUT1: begin
				ctl.emit_seg = 1'b1;
				if (st.manhattan) begin
					state_d = ST_OUT2;
				end else begin
					ctl.emit_last = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_OUT2: begin
				ctl.emit_seg = 1'b1;
				ctl.sel_leg2 = 1'b1;
				ctl.emit_last = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

>>> rtl/core/lrop_dp.sv
// Datapath: obstacle table, scan against points and legs, lengths, result word.
module lrop_dp
	import lrop_pkg::*;
#(
	parameter int OBSTACLE_SLOTS = OBSTACLE_SLOTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctrl_t                        ctl,
	output stat_t                        st,
	input  logic                         cfg_manhattan,
	input  logic signed [COORD_BITS-1:0] ax_in,
	input  logic signed [COORD_BITS-1:0] ay_in,
	input  logic signed [COORD_BITS-1:0] bx_in,
	input  logic signed [COORD_BITS-1:0] by_in,
	output logic                         done,
	output logic                         found,
	output logic signed [COORD_BITS-1:0] seg_start_x,
	output logic signed [COORD_BITS-1:0] seg_start_y,
	output logic signed [COORD_BITS-1:0] seg_end_x,
	output logic signed [COORD_BITS-1:0] seg_end_y,
	output logic [LEN_BITS-1:0]          seg_length,
	output logic [LEN_BITS-1:0]          total_length,
	output logic                         bend_count,
	output logic                         last_segment
);
	localparam int CB = COORD_BITS;
	localparam int AW = (OBSTACLE_SLOTS > 1) ? $clog2(OBSTACLE_SLOTS) : 1;
	localparam int NW = $clog2(OBSTACLE_SLOTS + 1);
	localparam int DW = CB + 1;
	localparam int SQ_IN = 2 * DW + 1;
	localparam int SQ_OUT = DW + 1;
	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	logic signed [CB-1:0] ax_q, ay_q, bx_q, by_q;
	logic [NW-1:0] count_q;
	logic [NW:0]   idx_q;
	logic          pend_q;
	logic          blk_pt_q, cross_q, mid_blk_q, man_q;
	logic          leg_q;
	logic [LEN_BITS-1:0] len1_q, len2_q;
	logic signed [CB-1:0] mx, my;
	logic [AW-1:0] raddr;
	logic [4*CB-1:0] wdata, rdata;
	logic signed [CB-1:0] ol, ot, orr, ob;
	logic          last_read;

	always_comb begin
		wdata[4*CB-1 -: CB] = (ax_q < bx_q) ? ax_q : bx_q;
		wdata[3*CB-1 -: CB] = (ay_q < by_q) ? ay_q : by_q;
		wdata[2*CB-1 -: CB] = (ax_q < bx_q) ? bx_q : ax_q;
		wdata[CB-1:0]       = (ay_q < by_q) ? by_q : ay_q;
	end

	assign raddr = idx_q[AW-1:0];

	lrop_ram #(.WIDTH(4 * CB), .DEPTH(OBSTACLE_SLOTS)) u_tab (
		.clk   (clk),
		.we    (ctl.wr_obst && !st.full),
		.waddr (count_q[AW-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign ol  = rdata[4*CB-1 -: CB];
	assign ot  = rdata[3*CB-1 -: CB];
	assign orr = rdata[2*CB-1 -: CB];
	assign ob  = rdata[CB-1:0];

	assign st.full = (count_q == NW'(OBSTACLE_SLOTS));
	assign st.manhattan = man_q;

	function automatic logic in_rng(logic signed [CB-1:0] v, logic signed [CB-1:0] a,
		logic signed [CB-1:0] b);
		logic signed [CB-1:0] lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (v >= lo) && (v <= hi);
	endfunction

	function automatic logic inside_r(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
		logic signed [CB-1:0] l, logic signed [CB-1:0] t, logic signed [CB-1:0] r,
		logic signed [CB-1:0] b);
		return (l != r) && (t != b) && (x >= l) && (x <= r) && (y >= t) && (y <= b);
	endfunction

	// Entry idx_q-1 is on rdata while pend_q is set.
	logic hit_pt, hit_mid, hit_cross;
	logic h1, v2;
	assign mx = bx_q;
	assign my = ay_q;
	assign h1 = (ax_q != mx);
	assign v2 = (my != by_q);
	always_comb begin
		hit_pt = inside_r(ax_q, ay_q, ol, ot, orr, ob) || inside_r(bx_q, by_q, ol, ot, orr, ob);
		hit_mid = inside_r(mx, my, ol, ot, orr, ob);
		hit_cross = (h1 && (ot != ob) && in_rng(ay_q, ot, ob)
			&& (in_rng(ol, ax_q, mx) || in_rng(orr, ax_q, mx)))
			|| (v2 && (ol != orr) && in_rng(mx, ol, orr)
			&& (in_rng(ot, my, by_q) || in_rng(ob, my, by_q)));
	end

	assign last_read = (idx_q >= (NW + 1)'(count_q));
	assign st.scan_done = !pend_q && last_read;
	assign st.blocked = blk_pt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			pend_q <= 1'b0;
		end else begin
			if (ctl.clr_count) begin
				count_q <= '0;
			end else if (ctl.wr_obst && !st.full) begin
				count_q <= count_q + 1'b1;
			end
			if (ctl.scan_start) begin
				idx_q <= '0;
				pend_q <= 1'b0;
			end else if (ctl.scan_step) begin
				pend_q <= !last_read;
				if (!last_read) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ax_q <= ax_in;
			ay_q <= ay_in;
			bx_q <= bx_in;
			by_q <= by_in;
			man_q <= cfg_manhattan;
		end
		if (ctl.scan_start) begin
			blk_pt_q <= 1'b0;
			mid_blk_q <= 1'b0;
			cross_q <= 1'b0;
		end else if (ctl.scan_step && pend_q) begin
			blk_pt_q <= blk_pt_q | hit_pt;
			mid_blk_q <= mid_blk_q | hit_mid;
			cross_q <= cross_q | hit_cross;
		end
	end

	// Final corner after fallback.
	logic signed [CB-1:0] cx, cy;
	assign cx = (mid_blk_q || cross_q) ? ax_q : bx_q;
	assign cy = (mid_blk_q || cross_q) ? by_q : ay_q;

	logic signed [CB-1:0] p0x, p0y, p1x, p1y;
	always_comb begin
		if (!man_q) begin
			p0x = ax_q; p0y = ay_q; p1x = bx_q; p1y = by_q;
		end else if (!ctl.sel_leg2) begin
			p0x = ax_q; p0y = ay_q; p1x = cx; p1y = cy;
		end else begin
			p0x = cx; p0y = cy; p1x = bx_q; p1y = by_q;
		end
	end

	logic signed [DW-1:0] dx, dy;
	logic [DW-1:0] adx, ady;
	logic [2*DW-1:0] sqx, sqy;
	logic [SQ_IN-1:0] rad;
	assign dx = DW'(p1x) - DW'(p0x);
	assign dy = DW'(p1y) - DW'(p0y);
	assign adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign sqx = adx * adx;
	assign sqy = ady * ady;
	assign rad = SQ_IN'(sqx) + SQ_IN'(sqy);

	logic [SQ_OUT-1:0] root;
	logic sq_done;
	lrop_sqrt #(.IN_BITS(SQ_IN + 1), .OUT_BITS(SQ_OUT)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.sqrt_start),
		.radicand ({1'b0, rad}),
		.done     (sq_done),
		.root     (root)
	);
	assign st.sqrt_done = sq_done;

	logic [LEN_BITS-1:0] root_sat;
	assign root_sat = (root > SQ_OUT'(LEN_MAX)) ? LEN_MAX : LEN_BITS'(root);

	// The leg under way is latched at start, since the select moves on when the root lands.
	always_ff @(posedge clk) begin
		if (ctl.sqrt_start) begin
			leg_q <= ctl.sel_leg2;
		end
		if (sq_done) begin
			if (leg_q) begin
				len2_q <= root_sat;
			end else begin
				len1_q <= root_sat;
			end
		end
	end

	logic [LEN_BITS:0] tot;
	assign tot = man_q ? ({1'b0, len1_q} + {1'b0, len2_q}) : {1'b0, len1_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.emit_fail || ctl.emit_seg;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_fail) begin
			found <= 1'b0;
			seg_start_x <= '0;
			seg_start_y <= '0;
			seg_end_x <= '0;
			seg_end_y <= '0;
			seg_length <= '0;
			total_length <= '0;
			bend_count <= 1'b0;
			last_segment <= 1'b1;
		end else if (ctl.emit_seg) begin
			found <= 1'b1;
			seg_start_x <= p0x;
			seg_start_y <= p0y;
			seg_end_x <= p1x;
			seg_end_y <= p1y;
			seg_length <= ctl.sel_leg2 ? len2_q : len1_q;
			total_length <= tot[LEN_BITS] ? LEN_MAX : tot[LEN_BITS-1:0];
			bend_count <= man_q && (ax_q != bx_q) && (ay_q != by_q);
			last_segment <= ctl.emit_last;
		end
	end
endmodule

>>> rtl/core/lrop_chk.sv
// Port-level checker for the route planner and its bind statement.
module lrop_chk (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic done,
	input logic found,
	input logic last_segment,
	input logic bend_count
);
	a_fail_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> last_segment) else $error("failure word without last flag");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last_segment |-> busy) else $error("first leg while idle");
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		done && !last_segment |=> done && last_segment)
		else $error("second leg missing");
	a_fail_bend: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> !bend_count) else $error("bend on failure word");
endmodule

bind l_route_obstacle_planner lrop_chk u_lrop_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.busy         (busy),
	.done         (done),
	.found        (found),
	.last_segment (last_segment),
	.bend_count   (bend_count)
);

>>> tb/sv/tb_l_route_obstacle_planner.sv
// Self-checking testbench of the obstacle route planner with its own route predictor.
`timescale 1ns / 1ps

module tb_l_route_obstacle_planner;
	import lrop_pkg::*;

	localparam int CB = 24;
	localparam int SLOTS = 16;
	localparam int WATCHDOG = 20000;
	localparam logic [24:0] LEN_SAT = 25'h1ffffff;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct {
		kind_t  k;
		coord_t ax, ay, bx, by;
	} cmd_t;

	typedef struct {
		logic        found;
		coord_t      sx, sy, ex, ey;
		logic [24:0] len, total;
		logic        bend, last;
	} seg_t;

	typedef struct {
		longint l, t, r, b;
	} box_t;

	logic clk, arst_n;
	logic start, busy;
	logic [1:0] kind;
	coord_t point_a_x, point_a_y, point_b_x, point_b_y;
	logic cfg_valid, cfg_ready, cfg_data;
	logic done, found;
	coord_t seg_start_x, seg_start_y, seg_end_x, seg_end_y;
	logic [24:0] seg_length, total_length;
	logic bend_count, last_segment;

	l_route_obstacle_planner dut (.*);

	cmd_t pending[$];
	seg_t expected_segs[$];
	box_t boxes[SLOTS];
	int box_count;
	bit manhattan_mode;
	int errors;
	int sender_idle;
	int quiet_cycles;
	bit hold_off;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	task automatic report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic bit point_free(longint x, longint y);
		for (int i = 0; i < box_count; i++) begin
			if (boxes[i].l == boxes[i].r || boxes[i].t == boxes[i].b)
				continue;
			if (x >= boxes[i].l && x <= boxes[i].r && y >= boxes[i].t && y <= boxes[i].b)
				return 0;
		end
		return 1;
	endfunction

	function automatic bit between(longint v, longint a, longint b);
		return v >= (a < b ? a : b) && v <= (a < b ? b : a);
	endfunction

	function automatic bit leg_hits(longint x0, longint y0, longint x1, longint y1);
		bit h, v;
		h = (y0 == y1) && (x0 != x1);
		v = (x0 == x1) && (y0 != y1);
		if (!h && !v)
			return 0;
		for (int i = 0; i < box_count; i++) begin
			if (h) begin
				if (boxes[i].t != boxes[i].b && between(y0, boxes[i].t, boxes[i].b) &&
					(between(boxes[i].l, x0, x1) || between(boxes[i].r, x0, x1)))
					return 1;
			end else begin
				if (boxes[i].l != boxes[i].r && between(x0, boxes[i].l, boxes[i].r) &&
					(between(boxes[i].t, y0, y1) || between(boxes[i].b, y0, y1)))
					return 1;
			end
		end
		return 0;
	endfunction

	function automatic logic [24:0] euclid(longint x0, longint y0, longint x1, longint y1);
		longint unsigned dx, dy, n, r, b;
		dx = x1 > x0 ? x1 - x0 : x0 - x1;
		dy = y1 > y0 ? y1 - y0 : y0 - y1;
		n = dx * dx + dy * dy;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r > LEN_SAT ? LEN_SAT : r[24:0];
	endfunction

	task automatic predict_route(cmd_t c);
		longint ax, ay, bx, by, mx, my, tot;
		seg_t s;
		logic [24:0] l1, l2;
		ax = c.ax; ay = c.ay; bx = c.bx; by = c.by;
		case (c.k)
			KIND_ADD: begin
				if (box_count < SLOTS) begin
					boxes[box_count] = '{ax < bx ? ax : bx, ay < by ? ay : by,
						ax < bx ? bx : ax, ay < by ? by : ay};
					box_count++;
				end
			end
			KIND_CLEAR: box_count = 0;
			KIND_PLAN: begin
				s = '{default: 0};
				if (!point_free(ax, ay) || !point_free(bx, by)) begin
					s.last = 1;
					expected_segs.push_back(s);
				end else if (!manhattan_mode) begin
					l1 = euclid(ax, ay, bx, by);
					s = '{1, c.ax, c.ay, c.bx, c.by, l1, l1, 0, 1};
					expected_segs.push_back(s);
				end else begin
					mx = bx; my = ay;
					if (!(point_free(mx, my) && !leg_hits(ax, ay, mx, my) &&
						!leg_hits(mx, my, bx, by))) begin
						mx = ax; my = by;
					end
					l1 = euclid(ax, ay, mx, my);
					l2 = euclid(mx, my, bx, by);
					tot = longint'(l1) + longint'(l2);
					if (tot > LEN_SAT)
						tot = LEN_SAT;
					s = '{1, c.ax, c.ay, coord_t'(mx), coord_t'(my), l1, tot[24:0],
						(ax != bx && ay != by), 0};
					expected_segs.push_back(s);
					s = '{1, coord_t'(mx), coord_t'(my), c.bx, c.by, l2, tot[24:0],
						(ax != bx && ay != by), 1};
					expected_segs.push_back(s);
				end
			end
			default: ;
		endcase
	endtask

	// Driver: presents queued words, with random idle gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			kind <= KIND_NONE;
			point_a_x <= 0; point_a_y <= 0; point_b_x <= 0; point_b_y <= 0;
		end else begin
			if (start && !busy) begin
				predict_route(pending.pop_front());
			end
			if (!(start && busy)) begin
				if (pending.size() > 0 && !hold_off && $urandom_range(99) >= sender_idle) begin
					start <= 1;
					kind <= pending[0].k;
					point_a_x <= pending[0].ax; point_a_y <= pending[0].ay;
					point_b_x <= pending[0].bx; point_b_y <= pending[0].by;
				end else begin
					start <= 0;
				end
			end
		end
	end

	// Monitor: checks each result word against the oldest prediction.
	always @(posedge clk) begin
		seg_t e;
		if (arst_n) begin
			quiet_cycles <= (start && !busy) || done ? 0 : quiet_cycles + 1;
			if (done) begin
				if (expected_segs.size() == 0) begin
					report("result word with none expected");
				end else begin
					e = expected_segs.pop_front();
					if (found !== e.found || seg_start_x !== e.sx || seg_start_y !== e.sy ||
						seg_end_x !== e.ex || seg_end_y !== e.ey || seg_length !== e.len ||
						total_length !== e.total || bend_count !== e.bend ||
						last_segment !== e.last)
						report($sformatf({"got %0d (%0d,%0d)-(%0d,%0d) l%0d t%0d b%0d e%0d, ",
							"want %0d (%0d,%0d)-(%0d,%0d) l%0d t%0d b%0d e%0d"},
							found, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
							seg_length, total_length, bend_count, last_segment,
							e.found, e.sx, e.sy, e.ex, e.ey, e.len, e.total, e.bend, e.last));
				end
			end
			if (quiet_cycles > WATCHDOG) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic coord_t rand_coord(bit near);
		case ($urandom_range(5))
			0: return coord_t'($urandom);
			1: return $urandom_range(1) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
			default: return near ? coord_t'($signed($urandom_range(400)) - 200)
				: coord_t'($signed($urandom_range(4000)) - 2000);
		endcase
	endfunction

	task automatic queue_cmd(kind_t k, coord_t ax, coord_t ay, coord_t bx, coord_t by);
		cmd_t c;
		c = '{k, ax, ay, bx, by};
		pending.push_back(c);
	endtask

	task automatic drain();
		while (pending.size() > 0 || expected_segs.size() > 0 || busy || start)
			@(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_mode(bit m);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		manhattan_mode = m;
	endtask

	task automatic random_phase(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 30)
				queue_cmd(KIND_ADD, rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1));
			else if (r < 35)
				queue_cmd(KIND_CLEAR, rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0));
			else if (r < 38)
				queue_cmd(KIND_NONE, rand_coord(0), rand_coord(0), rand_coord(0), rand_coord(0));
			else
				queue_cmd(KIND_PLAN, rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1));
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = 0;
		manhattan_mode = 1;
		sender_idle = 0;
		hold_off = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed words under the reset mode.
		queue_cmd(KIND_PLAN, 24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
		queue_cmd(KIND_PLAN, 24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff);
		queue_cmd(KIND_PLAN, 10, 10, 10, 10);
		queue_cmd(KIND_PLAN, 0, 5, 0, 50);
		queue_cmd(KIND_ADD, 100, 100, 0, 0);
		queue_cmd(KIND_ADD, 200, 0, 200, 50);
		queue_cmd(KIND_PLAN, 100, 50, 300, 300);
		queue_cmd(KIND_PLAN, -50, 10, 150, 60);
		queue_cmd(KIND_PLAN, -50, 100, 150, 200);
		queue_cmd(KIND_PLAN, -50, 0, 300, 0);
		queue_cmd(KIND_NONE, 1, 2, 3, 4);
		queue_cmd(KIND_CLEAR, 0, 0, 0, 0);
		for (int i = 0; i < SLOTS + 2; i++)
			queue_cmd(KIND_ADD, coord_t'(i * 20), 500, coord_t'(i * 20 + 10), 510);
		queue_cmd(KIND_PLAN, 0, 400, 500, 600);
		drain();

		write_mode(0);
		queue_cmd(KIND_PLAN, 24'sh800000, 24'sh800000, 24'sh7fffff, 24'sh7fffff);
		queue_cmd(KIND_PLAN, 5, 505, 0, 0);
		queue_cmd(KIND_CLEAR, 0, 0, 0, 0);
		random_phase(100);
		drain();

		write_mode(1);
		random_phase(100);
		drain();
		sender_idle = 72;
		random_phase(100);
		drain();
		write_mode(0);
		sender_idle = 37;
		random_phase(60);
		drain();
		write_mode(1);
		sender_idle = 0;
		random_phase(60);
		drain();

		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/lrop_pkg.sv
rtl/core/lrop_ram.sv
rtl/core/lrop_sqrt.sv
rtl/core/lrop_ctrl.sv
rtl/core/lrop_dp.sv
rtl/core/l_route_obstacle_planner.sv
rtl/core/lrop_chk.sv
tb/sv/tb_l_route_obstacle_planner.sv
